[hw/rtl/rtc_pkg.sv]
// Shared types, constants and lookup functions for the radio tuning control word block.
`default_nettype none
package rtc_pkg;

    // Field widths
    localparam int FREQ_W   = 32;
    localparam int REF_W    = 32;
    localparam int WORD_W   = 32;
    // y * CLOCK_HZ fits in 32 + 28 bits
    localparam int CLK_W    = 28;
    localparam int PROD_W   = FREQ_W + CLK_W;

    // Tuning constants: STEP_MULT = 0xE_5109_EC20, split into high and low words
    localparam logic [31:0]       STEP_MULT_LO = 32'h5109_EC20;
    localparam logic [3:0]        STEP_MULT_HI = 4'hE;
    localparam logic [CLK_W-1:0]  CLOCK_HZ     = 28'd150_000_000;
    localparam logic [REF_W-1:0]  REF_RESET    = 32'd150_000_000;

    localparam logic [31:0] TX_LOW_HZ  = 32'd3_500_000;
    localparam logic [31:0] TX_HIGH_HZ = 32'd29_700_000;
    localparam logic [4:0]  MUTE_ATTEN = 5'd18;
    localparam logic [3:0]  VOL_MAX    = 4'd9;
    localparam logic [2:0]  BAND_NONE  = 3'd4;

    // APB register map
    localparam int          PADDR_W     = 3;
    localparam logic [0:0]  REG_REF_CNT = 1'b0;

    // Operating modes
    typedef enum logic [2:0] {
        MODE_AM  = 3'd0,
        MODE_NFM = 3'd1,
        MODE_FM  = 3'd2,
        MODE_USB = 3'd3,
        MODE_LSB = 3'd4,
        MODE_CW  = 3'd5,
        MODE_R6  = 3'd6,
        MODE_R7  = 3'd7
    } t_mode;

    typedef struct packed {
        logic [31:0] frequency_hz;
        logic [2:0]  mode;
        logic [1:0]  agc_speed;
        logic [3:0]  volume;
        logic        mute;
        logic        test_signal;
        logic        usb_audio;
        logic [3:0]  band_override;
        logic [3:0]  mic_gain;
        logic        transmit;
    } t_item;

    typedef struct packed {
        logic [31:0] control_word;
        logic [31:0] nco_step;
    } t_result;

    // Attenuation code for a volume step, saturating above nine
    function automatic logic [4:0] atten_lut(input logic [3:0] vol);
        logic [3:0] v;
        v = (vol > VOL_MAX) ? VOL_MAX : vol;
        unique case (v)
            4'd0:    atten_lut = 5'd17;
            4'd1:    atten_lut = 5'd8;
            4'd2:    atten_lut = 5'd7;
            4'd3:    atten_lut = 5'd6;
            4'd4:    atten_lut = 5'd5;
            4'd5:    atten_lut = 5'd4;
            4'd6:    atten_lut = 5'd3;
            4'd7:    atten_lut = 5'd2;
            4'd8:    atten_lut = 5'd1;
            default: atten_lut = 5'd0;
        endcase
    endfunction

    // Receive IF offset per mode, two's complement
    function automatic logic [31:0] rx_offset(input logic [2:0] mode);
        unique case (t_mode'(mode))
            MODE_AM:  rx_offset = 32'(-12207);
            MODE_NFM: rx_offset = 32'(-24414);
            MODE_FM:  rx_offset = 32'(-24414);
            MODE_USB: rx_offset = 32'(-13732);
            MODE_LSB: rx_offset = 32'(-10681);
            MODE_CW:  rx_offset = 32'(-8138);
            default:  rx_offset = 32'd0;
        endcase
    endfunction

    // Band select from override or frequency range
    function automatic logic [2:0] pick_band(input logic [31:0] f, input logic [3:0] ovr);
        priority if (ovr[3])                             pick_band = ovr[2:0];
        else if (f >= 32'd2_000_000  && f < 32'd4_000_000)  pick_band = 3'd3;
        else if (f >= 32'd4_000_000  && f < 32'd8_000_000)  pick_band = 3'd2;
        else if (f >= 32'd8_000_000  && f < 32'd16_000_000) pick_band = 3'd1;
        else if (f >= 32'd16_000_000 && f < 32'd30_000_000) pick_band = 3'd0;
        else                                                pick_band = BAND_NONE;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/radio_tuning_control_word.sv]
// Top level: radio settings in, transceiver control word and NCO step out.
//
// Usage:
//   Input channel (i_valid/o_ready, i_item) carries one settings transaction.
//   Output channel (o_valid/i_ready, o_result) returns the control word and
//   the NCO phase increment for that transaction, in order.
//   APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds the
//   reference count at address 0; pready is always high. Write it only
//   while the pipeline is empty.
// Pipeline: stages A to D hold the offset, two multiplies and an add, then
//   60 divider stages (one quotient bit each), then the output register.
// Throughput: one transaction per cycle unless the output stalls, set by
//   the fully pipelined divider.
// Reset: synchronous, active low; clears all valid bits and loads the
//   reference count with 150000000.
// Stall: the whole pipeline holds only when its last stage is full and the
//   output register cannot hand off; while the last stage is empty it keeps
//   advancing and new transactions are still taken.
`default_nettype none
module radio_tuning_control_word (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire rtc_pkg::t_item                i_item,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output rtc_pkg::t_result                   o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rtc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import rtc_pkg::*;

    // Configuration register
    logic [REF_W-1:0] r_ref_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_cnt <= REF_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_REF_CNT) begin
            r_ref_cnt <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REF_CNT) ? r_ref_cnt : 32'd0;

    // Global advance: hold only if the last stage would be lost
    logic w_en;
    logic w_last_v;
    logic w_out_free;

    assign w_out_free = !o_valid || i_ready;
    assign w_en       = w_out_free || !w_last_v;
    assign o_ready    = w_en;

    // Stage A: control word and offset frequency
    logic              r_a_v;
    logic [WORD_W-1:0] r_a_ctl;
    logic [FREQ_W-1:0] r_a_f;
    logic [WORD_W-1:0] n_a_ctl;
    logic [FREQ_W-1:0] n_a_f;
    logic              n_tx_en;

    always_comb begin
        n_tx_en = i_item.transmit && i_item.frequency_hz >= TX_LOW_HZ
                  && i_item.frequency_hz <= TX_HIGH_HZ;
        n_a_ctl          = '0;
        n_a_ctl[2:0]     = i_item.mode;
        n_a_ctl[3]       = n_tx_en;
        n_a_ctl[5:4]     = i_item.agc_speed;
        n_a_ctl[6]       = i_item.test_signal;
        n_a_ctl[12:8]    = i_item.mute ? MUTE_ATTEN : atten_lut(i_item.volume);
        n_a_ctl[20]      = i_item.usb_audio;
        n_a_ctl[23:21]   = pick_band(i_item.frequency_hz, i_item.band_override);
        n_a_ctl[27:24]   = i_item.mic_gain;
        n_a_f = i_item.transmit ? i_item.frequency_hz
                                : i_item.frequency_hz + rx_offset(i_item.mode);
    end

    // Stage B: partial products of f * STEP_MULT
    logic              r_b_v;
    logic [WORD_W-1:0] r_b_ctl;
    logic [63:0]       r_b_plo;
    logic [31:0]       r_b_phi;

    // Stage C: bits 63..32 of the product
    logic              r_c_v;
    logic [WORD_W-1:0] r_c_ctl;
    logic [31:0]       r_c_y;

    // Stage D: y * CLOCK_HZ
    logic              r_d_v;
    logic [WORD_W-1:0] r_d_ctl;
    logic [PROD_W-1:0] r_d_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ctl  <= n_a_ctl;
            r_a_f    <= n_a_f;
            r_b_ctl  <= r_a_ctl;
            r_b_plo  <= 64'(r_a_f) * 64'(STEP_MULT_LO);
            r_b_phi  <= 32'(r_a_f * 32'(STEP_MULT_HI));
            r_c_ctl  <= r_b_ctl;
            r_c_y    <= r_b_plo[63:32] + r_b_phi;
            r_d_ctl  <= r_c_ctl;
            r_d_prod <= PROD_W'(r_c_y) * PROD_W'(CLOCK_HZ);
        end
    end

    // Divider pipeline; a zero count yields an all-ones quotient
    logic [WORD_W-1:0] w_quo;
    logic [WORD_W-1:0] w_ctl;

    rtc_div #(
        .NUM_W  (PROD_W),
        .DEN_W  (REF_W),
        .QUO_W  (WORD_W),
        .SIDE_W (WORD_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_v),
        .i_num   (r_d_prod),
        .i_den   (r_ref_cnt),
        .i_side  (r_d_ctl),
        .o_valid (w_last_v),
        .o_quo   (w_quo),
        .o_side  (w_ctl)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_out_free) begin
            o_valid <= w_last_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            o_result.control_word <= w_ctl;
            o_result.nco_step     <= w_quo;
        end
    end

    // Checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> (w_last_v && o_valid && !i_ready))
        else $error("pipeline stalled without a blocked result");

    a_no_output_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    a_ctl_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.control_word[31:28] == 4'd0
                     && o_result.control_word[19:13] == 7'd0
                     && o_result.control_word[7] == 1'b0))
        else $error("reserved control word bits set");

endmodule
`default_nettype wire

[hw/rtl/rtc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
`default_nettype none
module rtc_div #(
    parameter int NUM_W  = rtc_pkg::PROD_W,
    parameter int DEN_W  = rtc_pkg::REF_W,
    parameter int QUO_W  = rtc_pkg::WORD_W,
    parameter int SIDE_W = rtc_pkg::WORD_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [QUO_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]      o_side
);
    import rtc_pkg::*;

    // Stage k's outputs live at index k+1, the input at index 0
    logic              st_v    [0:NUM_W];
    logic [DEN_W-1:0]  st_rem  [0:NUM_W];
    logic [NUM_W-1:0]  st_num  [0:NUM_W];
    logic [QUO_W-1:0]  st_quo  [0:NUM_W];
    logic [SIDE_W-1:0] st_side [0:NUM_W];

    assign st_v[0]    = i_valid;
    assign st_rem[0]  = '0;
    assign st_num[0]  = i_num;
    assign st_quo[0]  = '0;
    assign st_side[0] = i_side;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0]   n_shift;
        logic             n_qbit;
        logic [DEN_W-1:0] n_rem;

        // Shift in the next dividend bit, subtract when it fits
        always_comb begin
            n_shift = {st_rem[k], st_num[k][NUM_W-1-k]};
            n_qbit  = (n_shift >= {1'b0, i_den});
            n_rem   = n_qbit ? DEN_W'(n_shift - {1'b0, i_den}) : n_shift[DEN_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                st_v[k+1] <= 1'b0;
            end else if (i_en) begin
                st_v[k+1] <= st_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                st_rem[k+1]  <= n_rem;
                st_num[k+1]  <= st_num[k];
                st_quo[k+1]  <= {st_quo[k][QUO_W-2:0], n_qbit};
                st_side[k+1] <= st_side[k];
            end
        end
    end

    assign o_valid = st_v[NUM_W];
    assign o_quo   = st_quo[NUM_W];
    assign o_side  = st_side[NUM_W];

endmodule
`default_nettype wire

[verif/radio_tuning_control_word_tb.sv]
// Self-checking testbench for the radio tuning control word block.
`default_nettype none
module radio_tuning_control_word_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rtc_pkg::*;

    localparam int LATENCY     = 65;
    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_item                i_item;
    logic                 o_valid;
    logic                 i_ready;
    t_result              o_result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    radio_tuning_control_word uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state and scoreboard
    logic [31:0] ref_count_model;
    t_result     pending_results[$];
    int          error_count;
    longint      cycle_count;
    bit          rx_hold_req;
    bit          stim_done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Attenuation code for a volume step
    function automatic logic [4:0] volume_atten(logic [3:0] vol, logic mute);
        logic [4:0] codes[10];
        codes = '{5'd17, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0};
        if (mute) return 5'd18;
        return (vol > 4'd9) ? codes[9] : codes[vol];
    endfunction

    // IF offset applied in receive
    function automatic logic [31:0] if_offset(t_mode m);
        case (m)
            MODE_AM:           return -32'sd12207;
            MODE_NFM, MODE_FM: return -32'sd24414;
            MODE_USB:          return -32'sd13732;
            MODE_LSB:          return -32'sd10681;
            MODE_CW:           return -32'sd8138;
            default:           return 32'd0;
        endcase
    endfunction

    function automatic logic [2:0] band_select(logic [31:0] f, logic [3:0] ovr);
        if (ovr[3])                    return ovr[2:0];
        if (f >= 2000000  && f < 4000000)  return 3'd3;
        if (f >= 4000000  && f < 8000000)  return 3'd2;
        if (f >= 8000000  && f < 16000000) return 3'd1;
        if (f >= 16000000 && f < 30000000) return 3'd0;
        return 3'd4;
    endfunction

    // Expected control word and NCO step for one settings transaction
    function automatic t_result tuning_result(t_item it);
        t_result    r;
        logic [31:0] f;
        logic [63:0] prod;
        logic [63:0] scaled;
        r.control_word = '0;
        r.control_word[2:0]   = it.mode;
        r.control_word[5:4]   = it.agc_speed;
        r.control_word[6]     = it.test_signal;
        r.control_word[12:8]  = volume_atten(it.volume, it.mute);
        r.control_word[20]    = it.usb_audio;
        r.control_word[23:21] = band_select(it.frequency_hz, it.band_override);
        r.control_word[27:24] = it.mic_gain;
        r.control_word[3]     = it.transmit && it.frequency_hz >= 3500000
                                && it.frequency_hz <= 29700000;
        f = it.transmit ? it.frequency_hz
                        : it.frequency_hz + if_offset(t_mode'(it.mode));
        prod   = 64'(f) * 64'd61489146912;
        scaled = 64'(prod[63:32]) * 64'd150000000;
        r.nco_step = (ref_count_model == 0) ? 32'hFFFF_FFFF
                                            : 32'(scaled / 64'(ref_count_model));
        return r;
    endfunction

    function automatic t_item random_item();
        t_item it;
        it = t_item'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: it.frequency_hz = $urandom_range(0, 40000000);
            1: it.frequency_hz = $urandom_range(0, 30000);
            2: it.frequency_hz = $urandom_range(3400000, 29800000);
            default: ;
        endcase
        return it;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)  return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic apb_write(logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_W'({REG_REF_CNT, 2'b00}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        ref_count_model = val;
    endtask

    // Offer one transaction and hold it until accepted; valid stays high
    // so the next transaction can follow back to back
    task automatic send_item(t_item it);
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(tuning_result(it));
    endtask

    task automatic send_with_gap(t_item it);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        send_item(it);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transaction %h", o_result);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result.control_word !== exp_r.control_word) begin
                    $error("control_word expected %h actual %h",
                           exp_r.control_word, o_result.control_word);
                    error_count++;
                end
                if (o_result.nco_step !== exp_r.nco_step) begin
                    $error("nco_step expected %h actual %h",
                           exp_r.nco_step, o_result.nco_step);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("radio_tuning_control_word test failed");
                $finish;
            end
        end
    end

    // Directed stimulus table; expected control word given where obvious
    typedef struct {
        t_item       it;
        bit          has_cw;
        logic [31:0] cw;
    } t_row;

    t_row dir_rows[$];

    function automatic t_item mk(logic [31:0] f, t_mode m, logic [3:0] vol,
                                 logic mute, logic [3:0] ovr, logic tx);
        t_item it;
        it = '0;
        it.frequency_hz = f; it.mode = m; it.volume = vol; it.mute = mute;
        it.band_override = ovr; it.transmit = tx;
        return it;
    endfunction

    initial begin
        t_item it;
        t_result r;
        int      n;
        error_count = 0; stim_done = 0; rx_hold_req = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_item = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        ref_count_model = 32'd150000000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Muted, band none, zero frequency: attenuation 18, band 4
        dir_rows.push_back('{mk(0, MODE_AM, 0, 1, 0, 0), 1, 32'h0080_1200});
        dir_rows.push_back('{mk(0, MODE_AM, 0, 0, 0, 1), 1, 32'h0080_1100});
        // Volume above nine saturates to attenuation 0
        dir_rows.push_back('{mk(0, MODE_AM, 15, 0, 0, 1), 1, 32'h0080_0000});
        dir_rows.push_back('{mk(0, MODE_AM, 9, 0, 4'hF, 1), 1, 32'h00E0_0000});
        // Transmit enable edges
        dir_rows.push_back('{mk(3500000, MODE_CW, 9, 0, 0, 1), 1, 32'h0060_000D});
        dir_rows.push_back('{mk(3499999, MODE_CW, 9, 0, 0, 1), 1, 32'h0060_0005});
        dir_rows.push_back('{mk(29700000, MODE_USB, 9, 0, 0, 1), 1, 32'h0000_000B});
        dir_rows.push_back('{mk(29700001, MODE_USB, 9, 0, 0, 1), 1, 32'h0000_0003});
        // Band edges, override with band 0
        dir_rows.push_back('{mk(2000000, MODE_LSB, 9, 0, 0, 0), 1, 32'h0060_0004});
        dir_rows.push_back('{mk(30000000, MODE_NFM, 9, 0, 4'h8, 0), 1, 32'h0000_0001});
        dir_rows.push_back('{mk(16000000, MODE_FM, 9, 0, 0, 0), 1, 32'h0000_0002});
        dir_rows.push_back('{mk(8000000, MODE_R6, 9, 0, 0, 0), 1, 32'h0020_0006});
        dir_rows.push_back('{mk(4000000, MODE_R7, 9, 0, 0, 0), 1, 32'h0040_0007});
        // Offset wrap and large product
        dir_rows.push_back('{mk(100, MODE_NFM, 3, 0, 0, 0), 0, '0});
        dir_rows.push_back('{mk(32'hFFFF_FFFF, MODE_AM, 3, 0, 0, 1), 0, '0});
        dir_rows.push_back('{mk(32'hFFFF_FFFF, MODE_CW, 3, 0, 0, 0), 0, '0});
        it = '1;
        dir_rows.push_back('{it, 0, '0});

        foreach (dir_rows[k]) begin
            r = tuning_result(dir_rows[k].it);
            if (dir_rows[k].has_cw && r.control_word !== dir_rows[k].cw) begin
                $error("control_word table expected %h actual %h",
                       dir_rows[k].cw, r.control_word);
                error_count++;
            end
            send_with_gap(dir_rows[k].it);
        end
        drain();

        // Reference count settings including extremes and zero
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: apb_write(32'd1);
                1: apb_write(32'hFFFF_FFFF);
                2: apb_write(32'd0);
                3: apb_write($urandom_range(100000000, 200000000));
                default: apb_write(32'd150000000);
            endcase
            n = (ph == 4) ? 200 : 100;
            for (int k = 0; k < n; k++) begin
                // Long receiver hold-off while the sender keeps offering
                if (ph == 4 && k == 50) begin
                    rx_hold_req = 1'b1;
                    for (int j = 0; j < 100; j++) send_item(random_item());
                end
                if ((k % 40) < 15) send_item(random_item());
                else send_with_gap(random_item());
            end
            drain();
        end

        stim_done = 1;
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("radio_tuning_control_word test passed");
        end else begin
            $display("radio_tuning_control_word test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
